FILE: rtl/gamma_contrast_brightness_ramp_defines.svh
// Assertion macros shared by the ramp RTL.
`ifndef GAMMA_CONTRAST_BRIGHTNESS_RAMP_DEFINES_SVH
`define GAMMA_CONTRAST_BRIGHTNESS_RAMP_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define GCB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// A condition that must never be seen outside reset.
`define GCB_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

FILE: rtl/gcb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gcb_pkg;

  localparam int FRAC_BITS = 20;
  localparam int V_W       = 31;   // Q1.30 mantissa of the power
  localparam int G_W       = 15;
  localparam int C_W       = 14;
  localparam int B_W       = 13;
  localparam int OUT_W     = 16;
  localparam int P_W       = 17;   // Q1.16 power, at most 1.0
  localparam int CFG_AW    = 4;
  localparam int CFG_DW    = 32;

  typedef enum logic [1:0] {
    REG_GAMMA      = 2'd0,
    REG_CONTRAST   = 2'd1,
    REG_BRIGHTNESS = 2'd2,
    REG_IDENTITY   = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [C_W-1:0] contrast;
    logic [B_W-1:0] brightness;
  } cfg_t;

  typedef struct packed {
    logic             ident;
    logic             zero;
    logic             full;
    logic [OUT_W-1:0] ival;
  } side_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
    logic [63:0] x;
    logic [63:0] r;
    logic [63:0] b;
    x = x_in;
    r = '0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Truncated log2 in Q.20 by repeated squaring of a Q1.30 mantissa.
  function automatic logic [63:0] log2_q20(input logic [63:0] x);
    logic [63:0] n;
    logic [63:0] m;
    logic [63:0] frac;
    n = '0;
    frac = '0;
    while ((x >> (n + 1)) != 0) n = n + 1;
    m = x << (30 - n);
    for (int k = 0; k < FRAC_BITS; k++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        frac = frac | 64'd1;
      end
    end
    return (n << FRAC_BITS) | frac;
  endfunction

  // Factor 2^(-2^-k) in Q1.30 for k = 1 .. FRAC_BITS.
  function automatic logic [V_W-1:0] exp_factor(input int k);
    logic [63:0] f;
    f = isqrt64(64'd1 << 59);
    for (int j = 1; j < k; j++) f = isqrt64(f << 30);
    return f[V_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/gcb_div.sv
`timescale 1ns / 1ps
`default_nettype none

module gcb_div import gcb_pkg::*; #(
  parameter int DW = 35
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          vld_i,
  input  wire logic [DW-1:0] dvd_i,
  input  wire logic [G_W-1:0] dvs_i,
  output logic               vld_o,
  output logic [DW-1:0]      quo_o
);

  logic [DW-1:0]  vld_q;
  logic [DW-1:0]  dq_q  [DW];
  logic [G_W-1:0] rem_q [DW];

  // One quotient bit per stage; the dividend shifts out as the quotient shifts in.
  for (genvar j = 0; j < DW; j++) begin : g_st
    logic [G_W-1:0] pr;
    logic [DW-1:0]  pdq;
    logic           pv;
    logic [G_W:0]   t;
    logic           ge;

    if (j == 0) begin : g_first
      assign pr  = '0;
      assign pdq = dvd_i;
      assign pv  = vld_i;
    end else begin : g_next
      assign pr  = rem_q[j-1];
      assign pdq = dq_q[j-1];
      assign pv  = vld_q[j-1];
    end

    assign t  = {pr, pdq[DW-1]};
    assign ge = (t >= {1'b0, dvs_i});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else begin
        vld_q[j] <= pv;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[j] <= ge ? G_W'(t - {1'b0, dvs_i}) : t[G_W-1:0];
      dq_q[j]  <= {pdq[DW-2:0], ge};
    end
  end

  assign vld_o = vld_q[DW-1];
  assign quo_o = dq_q[DW-1];

endmodule

`default_nettype wire

FILE: rtl/gcb_exp.sv
`timescale 1ns / 1ps
`default_nettype none

module gcb_exp import gcb_pkg::*; #(
  parameter int DW = 35
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          vld_i,
  input  wire logic [DW-1:0] d_i,
  output logic               vld_o,
  output logic [P_W-1:0]     p_o
);

  localparam int N_W = DW - FRAC_BITS;

  logic [FRAC_BITS-1:0] vld_q;
  logic [V_W-1:0]       v_q [FRAC_BITS];
  logic [FRAC_BITS-1:0] r_q [FRAC_BITS];
  logic [N_W-1:0]       n_q [FRAC_BITS];
  logic                 out_vld_q;
  logic [P_W-1:0]       p_q;
  logic [V_W-1:0]       sh;

  // Stage k multiplies in 2^(-2^-k) when fraction bit k is set.
  for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_st
    localparam logic [V_W-1:0] F = exp_factor(k);
    logic [V_W-1:0]       pv_v;
    logic [FRAC_BITS-1:0] pr;
    logic [N_W-1:0]       pn;
    logic                 pv;
    logic [2*V_W-1:0]     prod;

    if (k == 1) begin : g_first
      assign pv_v = V_W'(1) << 30;
      assign pr   = d_i[FRAC_BITS-1:0];
      assign pn   = d_i[DW-1:FRAC_BITS];
      assign pv   = vld_i;
    end else begin : g_next
      assign pv_v = v_q[k-2];
      assign pr   = r_q[k-2];
      assign pn   = n_q[k-2];
      assign pv   = vld_q[k-2];
    end

    assign prod = pv_v * F;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k-1] <= 1'b0;
      end else begin
        vld_q[k-1] <= pv;
      end
    end

    always_ff @(posedge clk_i) begin
      v_q[k-1] <= pr[FRAC_BITS-k] ? prod[60:30] : pv_v;
      r_q[k-1] <= pr;
      n_q[k-1] <= pn;
    end
  end

  assign sh = v_q[FRAC_BITS-1] >> n_q[FRAC_BITS-1][4:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= vld_q[FRAC_BITS-1];
    end
  end

  // The integer part of the exponent is a right shift; 31 or more empties it.
  always_ff @(posedge clk_i) begin
    if (n_q[FRAC_BITS-1] >= N_W'(31)) begin
      p_q <= '0;
    end else begin
      p_q <= sh[V_W-1:14];
    end
  end

  assign vld_o = out_vld_q;
  assign p_o   = p_q;

endmodule

`default_nettype wire

FILE: rtl/gcb_post.sv
`timescale 1ns / 1ps
`default_nettype none

module gcb_post import gcb_pkg::*; (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           vld_i,
  input  wire logic [P_W-1:0] p_i,
  input  wire cfg_t           cfg_i,
  output logic                vld_o,
  output logic [OUT_W-1:0]    res_o
);

  logic [3:0]              vld_q;
  logic signed [17:0]      diff;
  logic signed [32:0]      prod_d, prod_q;
  logic signed [32:0]      scaled;
  logic signed [17:0]      t1_d, t1_q;
  logic signed [19:0]      t2s;
  logic [P_W-1:0]          t2_d, t2_q;
  logic [31:0]             mul;
  logic [OUT_W-1:0]        res_d, res_q;

  assign diff   = $signed({1'b0, p_i}) - 18'sd32768;
  assign prod_d = diff * $signed({1'b0, cfg_i.contrast});

  // Arithmetic shift floors, which matches the rounding of negative products.
  assign scaled = (prod_q >>> 11) + 33'sd32768;
  always_comb begin
    if (scaled < -33'sd131072) begin
      t1_d = -18'sd131072;
    end else if (scaled > 33'sd131071) begin
      t1_d = 18'sd131071;
    end else begin
      t1_d = scaled[17:0];
    end
  end

  assign t2s = 20'(t1_q) + $signed({3'b0, cfg_i.brightness, 4'b0}) - 20'sd32768;
  always_comb begin
    if (t2s < 20'sd0) begin
      t2_d = '0;
    end else if (t2s > 20'sd65536) begin
      t2_d = P_W'(65536);
    end else begin
      t2_d = t2s[P_W-1:0];
    end
  end

  assign mul   = t2_q[15:0] * 16'hFFFF;
  assign res_d = t2_q[16] ? 16'hFFFF : mul[31:16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    t1_q   <= t1_d;
    t2_q   <= t2_d;
    res_q  <= res_d;
  end

  assign vld_o = vld_q[3];
  assign res_o = res_q;

endmodule

`default_nettype wire

FILE: rtl/gamma_contrast_brightness_ramp.sv
// Gamma, contrast and brightness ramp. One level is taken on every clock with
// start high; busy is always low. The corrected value (the plain ramp while
// identity is set) appears on ramp_value_o with done_o high for exactly one
// cycle. The pipeline is one input stage, $clog2(IN_BITS)+32 stages of the
// one-bit-per-stage divider for the exponent, twenty multiplier stages of the
// power plus one shift stage, and four stages of contrast, brightness and
// scaling. Results cannot be held off, so the sink must take every beat as it
// comes. The user must change registers only while the pipeline is empty; the
// block itself does not enforce it.
`timescale 1ns / 1ps
`default_nettype none
`include "gamma_contrast_brightness_ramp_defines.svh"

module gamma_contrast_brightness_ramp import gcb_pkg::*; #(
  parameter int IN_BITS = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [IN_BITS-1:0] level_i,
  output logic                    done_o,
  output logic [OUT_W-1:0]        ramp_value_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [CFG_AW-1:0]  paddr,
  input  wire logic [CFG_DW-1:0]  pwdata,
  output logic [CFG_DW-1:0]       prdata,
  output logic                    pready
);

  localparam int M     = 2**IN_BITS - 1;
  localparam int DEPTH = 2**IN_BITS;
  localparam int A_W   = $clog2(IN_BITS) + FRAC_BITS;
  localparam int DW    = A_W + 12;
  localparam int SB_N  = DW + 26;
  localparam int P_TAP = DW + 21;
  localparam int LAT   = DW + 26;
  localparam logic [63:0] L_MAX = log2_q20(64'(M));

  function automatic logic [OUT_W-1:0] ramp_of(input int i);
    logic [63:0] v;
    v = (64'(i) * 64'd65535) / M;
    return v[OUT_W-1:0];
  endfunction

  logic [G_W-1:0] gamma_q;
  logic [C_W-1:0] contrast_q;
  logic [B_W-1:0] brightness_q;
  logic           ident_q;
  logic           wr;
  reg_idx_e       widx;

  logic [A_W-1:0]   a_rom [DEPTH];
  logic [OUT_W-1:0] i_rom [DEPTH];

  logic           acc;
  logic           s0_vld_q;
  logic [A_W-1:0] a_q;
  side_t          sb_q [SB_N];
  side_t          side_d;
  logic [G_W-1:0] gd;

  logic           div_vld;
  logic [DW-1:0]  quo;
  logic           exp_vld;
  logic [P_W-1:0] exp_p;
  logic [P_W-1:0] p_in;
  logic           post_vld;
  logic [OUT_W-1:0] post_res;
  cfg_t           cfg;

  // Configuration port.
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign widx   = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gamma_q      <= G_W'(4096);
      contrast_q   <= C_W'(2048);
      brightness_q <= B_W'(2048);
      ident_q      <= 1'b1;
    end else if (wr) begin
      unique case (widx)
        REG_GAMMA:      gamma_q      <= pwdata[G_W-1:0];
        REG_CONTRAST:   contrast_q   <= pwdata[C_W-1:0];
        REG_BRIGHTNESS: brightness_q <= pwdata[B_W-1:0];
        REG_IDENTITY:   ident_q      <= pwdata[0];
        default:        ident_q      <= ident_q;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      REG_GAMMA:      prdata = CFG_DW'(gamma_q);
      REG_CONTRAST:   prdata = CFG_DW'(contrast_q);
      REG_BRIGHTNESS: prdata = CFG_DW'(brightness_q);
      REG_IDENTITY:   prdata = CFG_DW'(ident_q);
      default:        prdata = '0;
    endcase
  end

  // Constant tables: distance below full scale in log2, and the plain ramp.
  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_rom
    if (gi == 0) begin : g_zero
      assign a_rom[gi] = '0;
    end else begin : g_lvl
      assign a_rom[gi] = A_W'(L_MAX - log2_q20(64'(gi)));
    end
    assign i_rom[gi] = ramp_of(gi);
  end

  assign busy = 1'b0;
  assign acc  = start && !busy;

  assign side_d.ident = ident_q;
  assign side_d.zero  = (level_i == '0);
  assign side_d.full  = (level_i == IN_BITS'(M));
  assign side_d.ival  = i_rom[level_i];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else begin
      s0_vld_q <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q      <= a_rom[level_i];
    sb_q[0]  <= side_d;
    for (int j = 1; j < SB_N; j++) sb_q[j] <= sb_q[j-1];
  end

  assign gd = (gamma_q == '0) ? G_W'(1) : gamma_q;

  gcb_div #(.DW(DW)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (s0_vld_q),
    .dvd_i  ({a_q, 12'b0}),
    .dvs_i  (gd),
    .vld_o  (div_vld),
    .quo_o  (quo)
  );

  gcb_exp #(.DW(DW)) u_exp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (div_vld),
    .d_i    (quo),
    .vld_o  (exp_vld),
    .p_o    (exp_p)
  );

  assign p_in           = sb_q[P_TAP].zero ? '0 : exp_p;
  assign cfg.contrast   = contrast_q;
  assign cfg.brightness = brightness_q;

  gcb_post u_post (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (exp_vld),
    .p_i    (p_in),
    .cfg_i  (cfg),
    .vld_o  (post_vld),
    .res_o  (post_res)
  );

  assign done_o       = post_vld;
  assign ramp_value_o = sb_q[SB_N-1].ident ? sb_q[SB_N-1].ival : post_res;

  `GCB_ASSERT_IMP(a_done_latency, done_o, $past(acc, LAT), "done without a level accepted")
  `GCB_ASSERT_NEVER(a_power_range, exp_vld && (exp_p > P_W'(65536)), "power above one")
  `GCB_ASSERT_IMP(a_full_is_one, exp_vld && sb_q[P_TAP].full, exp_p == P_W'(65536), "full level not one")

endmodule

`default_nettype wire
